// File: rtl/ppp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_pkg
// shared types, constants and register codes of the point projection block
// ----------------------------------------------------------------------------
package ppp_pkg;

   // default camera geometry
   localparam int DEF_IMG_WIDTH  = 1960;
   localparam int DEF_IMG_HEIGHT = 1080;
   localparam int DEF_CENTER_U   = 190;
   localparam int DEF_CENTER_V   = 160;

   // datapath widths
   localparam int COORD_W  = 32;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int QUAT_W   = 15;
   localparam int FOCAL_W  = 16;
   localparam int PIXEL_W  = 16;
   localparam int DIV_BITS = 17;

   // queue sizes
   localparam int MID_DEPTH_LOG = 2;
   localparam int OUT_DEPTH_LOG = 1;

   // register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // register reset values
   localparam logic signed [QUAT_W-1:0]  QUAT_W_RST  = -15'sd8192;
   localparam logic signed [QUAT_W-1:0]  QUAT_X_RST  = 15'sd8192;
   localparam logic signed [QUAT_W-1:0]  QUAT_Y_RST  = 15'sd8192;
   localparam logic signed [QUAT_W-1:0]  QUAT_Z_RST  = -15'sd8192;
   localparam logic signed [COORD_W-1:0] TRANS_RST   = 32'sd131072;
   localparam logic [FOCAL_W-1:0]        FOCAL_RST   = 16'd400;

   typedef enum logic [2:0] {
      REG_QUAT_W  = 3'd0,
      REG_QUAT_X  = 3'd1,
      REG_QUAT_Y  = 3'd2,
      REG_QUAT_Z  = 3'd3,
      REG_TRANS_X = 3'd4,
      REG_TRANS_Y = 3'd5,
      REG_TRANS_Z = 3'd6,
      REG_FOCAL   = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic signed [QUAT_W-1:0] w;
      logic signed [QUAT_W-1:0] x;
      logic signed [QUAT_W-1:0] y;
      logic signed [QUAT_W-1:0] z;
   } quat_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] dz;
   } diff_type;

   typedef struct packed {
      logic signed [PIXEL_W-1:0] pixel_u;
      logic signed [PIXEL_W-1:0] pixel_v;
      logic                      in_image;
      logic                      zero_depth;
   } result_type;

endpackage

// File: rtl/ppp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_fifo
// small first-in first-out queue with full and empty flags
// ----------------------------------------------------------------------------
module ppp_fifo #(
   parameter int WIDTH     = 1,
   parameter int DEPTH_LOG = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int DEPTH = 1 << DEPTH_LOG;

   logic [WIDTH-1:0]   mem_ff [DEPTH];
   logic [DEPTH_LOG:0] wr_ff, wr_in;
   logic [DEPTH_LOG:0] rd_ff, rd_in;
   logic               do_push, do_pop;

   assign empty   = (wr_ff == rd_ff);
   assign full    = (wr_ff[DEPTH_LOG] != rd_ff[DEPTH_LOG]) &&
                    (wr_ff[DEPTH_LOG-1:0] == rd_ff[DEPTH_LOG-1:0]);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign wr_in   = do_push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in   = do_pop ? rd_ff + 1'b1 : rd_ff;
   assign rdata   = mem_ff[rd_ff[DEPTH_LOG-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff[DEPTH_LOG-1:0]] <= wdata;
      end
   end

endmodule

// File: rtl/ppp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_front
// takes world points, removes the camera translation and queues them
// ----------------------------------------------------------------------------
module ppp_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [ppp_pkg::COORD_W-1:0]    req_world_x,
   input  logic signed [ppp_pkg::COORD_W-1:0]    req_world_y,
   input  logic signed [ppp_pkg::COORD_W-1:0]    req_world_z,
   input  logic signed [ppp_pkg::COORD_W-1:0]    trans_x,
   input  logic signed [ppp_pkg::COORD_W-1:0]    trans_y,
   input  logic signed [ppp_pkg::COORD_W-1:0]    trans_z,
   input  logic                                  mid_pop,
   output logic                                  mid_empty,
   output ppp_pkg::diff_type                     mid_diff
);
   import ppp_pkg::*;

   diff_type             diff_in;
   logic [$bits(diff_type)-1:0] head;

   // exact 33 bit differences
   assign diff_in.dx = DIFF_W'(req_world_x) - DIFF_W'(trans_x);
   assign diff_in.dy = DIFF_W'(req_world_y) - DIFF_W'(trans_y);
   assign diff_in.dz = DIFF_W'(req_world_z) - DIFF_W'(trans_z);

   ppp_fifo #(
      .WIDTH     ($bits(diff_type)),
      .DEPTH_LOG (MID_DEPTH_LOG)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (diff_in),
      .full  (req_full),
      .pop   (mid_pop),
      .rdata (head),
      .empty (mid_empty)
   );

   assign mid_diff = diff_type'(head);

endmodule

// File: rtl/ppp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ppp_div #(
   parameter int QBITS = 17,
   parameter int MAG_W = 60,
   parameter int DEN_W = 40
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [MAG_W-1:0] mag,
   input  logic [DEN_W-1:0] den,
   output logic [QBITS-1:0] quo
);
   logic [MAG_W-1:0] rem_ff [QBITS];
   logic [DEN_W-1:0] den_ff [QBITS];
   logic [QBITS-1:0] quo_ff [QBITS];

   for (genvar i = 0; i < QBITS; i++) begin : g_step
      logic [MAG_W-1:0] rem_src;
      logic [DEN_W-1:0] den_src;
      logic [QBITS-1:0] quo_src;
      logic [MAG_W-1:0] trial;
      logic             take;

      if (i == 0) begin : g_first
         assign rem_src = mag;
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign den_src = den_ff[i-1];
         assign quo_src = quo_ff[i-1];
      end

      // msb first
      assign trial = MAG_W'(den_src) << (QBITS - 1 - i);
      assign take  = (rem_src >= trial);

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i] <= take ? rem_src - trial : rem_src;
            den_ff[i] <= den_src;
            quo_ff[i] <= quo_src | (take ? (QBITS'(1) << (QBITS - 1 - i)) : '0);
         end
      end
   end

   assign quo = quo_ff[QBITS-1];

endmodule

// File: rtl/ppp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_back
// rotation, perspective divide, rounding, saturation and bounds test
// ----------------------------------------------------------------------------
module ppp_back #(
   parameter int IMG_WIDTH  = ppp_pkg::DEF_IMG_WIDTH,
   parameter int IMG_HEIGHT = ppp_pkg::DEF_IMG_HEIGHT,
   parameter int CENTER_U   = ppp_pkg::DEF_CENTER_U,
   parameter int CENTER_V   = ppp_pkg::DEF_CENTER_V
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ppp_pkg::quat_type                 quat,
   input  logic [ppp_pkg::FOCAL_W-1:0]       focal_len,
   input  logic                              mid_empty,
   input  ppp_pkg::diff_type                 mid_diff,
   output logic                              mid_pop,
   input  logic                              out_full,
   output logic                              out_push,
   output ppp_pkg::result_type               out_result
);
   import ppp_pkg::*;

   localparam int QP_W    = 2 * QUAT_W;
   localparam int ROT_W   = 32;
   localparam int PROD_W  = ROT_W + DIFF_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int CAM_W   = SUM_W - 28;
   localparam int NUM_W   = CAM_W + 1 + FOCAL_W + 1;
   localparam int NP_W    = NUM_W + 2;
   localparam int DEN_W   = CAM_W + 1;
   localparam int MAG_W   = NP_W + 1;
   localparam int LIM_W   = NUM_W + 1;
   localparam int PIX_W   = DIV_BITS + 2;
   localparam int PRE     = 7;
   localparam int NUM_STG = PRE + DIV_BITS;

   localparam logic signed [ROT_W-1:0] ONE_Q28 = ROT_W'(1) <<< 28;
   localparam logic signed [15:0] K_LO_U = 16'(-CENTER_U);
   localparam logic signed [15:0] K_HI_U = 16'(IMG_WIDTH - CENTER_U);
   localparam logic signed [15:0] K_LO_V = 16'(-CENTER_V);
   localparam logic signed [15:0] K_HI_V = 16'(IMG_HEIGHT - CENTER_V);
   localparam logic signed [PIX_W-1:0] CU_X = PIX_W'(CENTER_U);
   localparam logic signed [PIX_W-1:0] CV_X = PIX_W'(CENTER_V);
   localparam logic signed [PIX_W-1:0] PIX_MAX = PIX_W'(32767);
   localparam logic signed [PIX_W-1:0] PIX_MIN = PIX_W'(-32768);

   typedef struct packed {
      logic neg_u;
      logic neg_v;
      logic ovf_u;
      logic ovf_v;
      logic in_bounds;
      logic zero;
   } side_type;

   // rotation matrix from the quaternion, two register stages
   logic signed [QP_W-1:0]  xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [QP_W-1:0]  wx_ff, wy_ff, wz_ff;
   logic signed [ROT_W-1:0] rot_ff [3][3];

   always_ff @(posedge clock) begin
      xx_ff <= QP_W'(quat.x * quat.x);
      yy_ff <= QP_W'(quat.y * quat.y);
      zz_ff <= QP_W'(quat.z * quat.z);
      xy_ff <= QP_W'(quat.x * quat.y);
      xz_ff <= QP_W'(quat.x * quat.z);
      yz_ff <= QP_W'(quat.y * quat.z);
      wx_ff <= QP_W'(quat.w * quat.x);
      wy_ff <= QP_W'(quat.w * quat.y);
      wz_ff <= QP_W'(quat.w * quat.z);
   end

   always_ff @(posedge clock) begin
      rot_ff[0][0] <= ONE_Q28 - ((ROT_W'(yy_ff) + ROT_W'(zz_ff)) <<< 1);
      rot_ff[0][1] <= (ROT_W'(xy_ff) - ROT_W'(wz_ff)) <<< 1;
      rot_ff[0][2] <= (ROT_W'(xz_ff) + ROT_W'(wy_ff)) <<< 1;
      rot_ff[1][0] <= (ROT_W'(xy_ff) + ROT_W'(wz_ff)) <<< 1;
      rot_ff[1][1] <= ONE_Q28 - ((ROT_W'(xx_ff) + ROT_W'(zz_ff)) <<< 1);
      rot_ff[1][2] <= (ROT_W'(yz_ff) - ROT_W'(wx_ff)) <<< 1;
      rot_ff[2][0] <= (ROT_W'(xz_ff) - ROT_W'(wy_ff)) <<< 1;
      rot_ff[2][1] <= (ROT_W'(yz_ff) + ROT_W'(wx_ff)) <<< 1;
      rot_ff[2][2] <= ONE_Q28 - ((ROT_W'(xx_ff) + ROT_W'(yy_ff)) <<< 1);
   end

   // pipeline control: everything moves together
   logic [NUM_STG-1:0] vld_ff, vld_in;
   logic               adv;

   assign adv      = !vld_ff[NUM_STG-1] || !out_full;
   assign out_push = vld_ff[NUM_STG-1] && !out_full;
   assign mid_pop  = adv && !mid_empty;
   assign vld_in   = adv ? {vld_ff[NUM_STG-2:0], mid_pop} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 0: dequeued difference
   logic signed [DIFF_W-1:0] d_ff [3];

   // stage 1: nine products
   logic signed [PROD_W-1:0] p_ff [3][3];

   // stage 2: camera point, floor to q16.16
   logic signed [CAM_W-1:0] c_ff [3];
   logic signed [SUM_W-1:0] sum_in [3];

   // stage 3: signed numerators and depth magnitude
   logic signed [NUM_W-1:0] nu_ff, nv_ff;
   logic [DEN_W-1:0]        den3_ff;
   logic                    zero3_ff;
   logic                    neg3_in;
   logic signed [CAM_W:0]   cs0_in, cs1_in, c2_in;
   logic signed [NUM_W-1:0] f_in;

   // stage 4: bounds test and rounding numerators
   logic signed [NP_W-1:0]  npu_ff, npv_ff;
   logic [DEN_W-1:0]        den4_ff;
   logic                    inside4_ff, zero4_ff;
   logic signed [LIM_W-1:0] den_x, nu_x, nv_x;
   logic                    inside_in;

   // stage 5: magnitudes for the divider
   logic [MAG_W-1:0]        magu5_ff, magv5_ff;
   logic [DEN_W:0]          den2_5_ff;
   side_type                side5_ff;
   logic signed [MAG_W-1:0] npu_x, npv_x, den2_x;

   // stage 6: overflow check
   logic [MAG_W-1:0]        magu6_ff, magv6_ff;
   logic [DEN_W:0]          den2_6_ff;
   side_type                side6_ff;
   logic [MAG_W-1:0]        lim6_in;

   side_type                side_ff [DIV_BITS];
   logic [DIV_BITS-1:0]     quo_u, quo_v;

   for (genvar k = 0; k < 3; k++) begin : g_sum
      assign sum_in[k] = SUM_W'(p_ff[k][0]) + SUM_W'(p_ff[k][1]) + SUM_W'(p_ff[k][2]);
   end

   assign neg3_in = c_ff[2][CAM_W-1];
   assign cs0_in  = neg3_in ? -(CAM_W+1)'(c_ff[0]) : (CAM_W+1)'(c_ff[0]);
   assign cs1_in  = neg3_in ? -(CAM_W+1)'(c_ff[1]) : (CAM_W+1)'(c_ff[1]);
   assign c2_in   = neg3_in ? -(CAM_W+1)'(c_ff[2]) : (CAM_W+1)'(c_ff[2]);
   assign f_in    = NUM_W'($signed({1'b0, focal_len}));

   assign den_x = $signed({{(LIM_W-DEN_W){1'b0}}, den3_ff});
   assign nu_x  = LIM_W'(nu_ff);
   assign nv_x  = LIM_W'(nv_ff);
   assign inside_in = (nu_x >= den_x * LIM_W'(K_LO_U)) && (nu_x < den_x * LIM_W'(K_HI_U)) &&
                      (nv_x >= den_x * LIM_W'(K_LO_V)) && (nv_x < den_x * LIM_W'(K_HI_V));

   assign npu_x  = MAG_W'(npu_ff);
   assign npv_x  = MAG_W'(npv_ff);
   assign den2_x = $signed({{(MAG_W-DEN_W-1){1'b0}}, den4_ff, 1'b0});

   assign lim6_in = MAG_W'(den2_5_ff) << DIV_BITS;

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 0
         d_ff[0] <= mid_diff.dx;
         d_ff[1] <= mid_diff.dy;
         d_ff[2] <= mid_diff.dz;
         // stage 1
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               p_ff[k][j] <= PROD_W'(rot_ff[k][j]) * PROD_W'(d_ff[j]);
            end
         end
         // stage 2
         for (int k = 0; k < 3; k++) begin
            c_ff[k] <= CAM_W'(sum_in[k] >>> 28);
         end
         // stage 3
         nu_ff    <= NUM_W'(cs0_in) * f_in;
         nv_ff    <= NUM_W'(cs1_in) * f_in;
         den3_ff  <= DEN_W'(c2_in);
         zero3_ff <= (c_ff[2] == '0);
         // stage 4: 2n + d
         npu_ff     <= (NP_W'(nu_ff) <<< 1) + NP_W'(den_x);
         npv_ff     <= (NP_W'(nv_ff) <<< 1) + NP_W'(den_x);
         den4_ff    <= den3_ff;
         inside4_ff <= inside_in;
         zero4_ff   <= zero3_ff;
         // stage 5: negative numerators floor through -n + 2d - 1
         magu5_ff <= npu_ff[NP_W-1] ? MAG_W'(den2_x - MAG_W'(1) - npu_x) : MAG_W'(npu_x);
         magv5_ff <= npv_ff[NP_W-1] ? MAG_W'(den2_x - MAG_W'(1) - npv_x) : MAG_W'(npv_x);
         den2_5_ff          <= {den4_ff, 1'b0};
         side5_ff.neg_u     <= npu_ff[NP_W-1];
         side5_ff.neg_v     <= npv_ff[NP_W-1];
         side5_ff.ovf_u     <= 1'b0;
         side5_ff.ovf_v     <= 1'b0;
         side5_ff.in_bounds <= inside4_ff && !zero4_ff;
         side5_ff.zero      <= zero4_ff;
         // stage 6: quotient would not fit
         magu6_ff  <= magu5_ff;
         magv6_ff  <= magv5_ff;
         den2_6_ff <= den2_5_ff;
         side6_ff  <= '{neg_u: side5_ff.neg_u, neg_v: side5_ff.neg_v,
                        ovf_u: (magu5_ff >= lim6_in), ovf_v: (magv5_ff >= lim6_in),
                        in_bounds: side5_ff.in_bounds, zero: side5_ff.zero};
         // sideband alongside the divider
         side_ff[0] <= side6_ff;
         for (int s = 1; s < DIV_BITS; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   ppp_div #(.QBITS(DIV_BITS), .MAG_W(MAG_W), .DEN_W(DEN_W + 1)) u_div_u (
      .clock (clock),
      .adv   (adv),
      .mag   (magu6_ff),
      .den   (den2_6_ff),
      .quo   (quo_u)
   );

   ppp_div #(.QBITS(DIV_BITS), .MAG_W(MAG_W), .DEN_W(DEN_W + 1)) u_div_v (
      .clock (clock),
      .adv   (adv),
      .mag   (magv6_ff),
      .den   (den2_6_ff),
      .quo   (quo_v)
   );

   function automatic logic signed [PIXEL_W-1:0] pixel_of(
      input logic [DIV_BITS-1:0]   quo,
      input logic                  neg,
      input logic                  ovf,
      input logic signed [PIX_W-1:0] center
   );
      logic signed [PIX_W-1:0] q;
      logic signed [PIX_W-1:0] t;
      q = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
      t = q + center;
      priority if (ovf && neg) begin
         return {1'b1, {(PIXEL_W-1){1'b0}}};
      end else if (ovf) begin
         return {1'b0, {(PIXEL_W-1){1'b1}}};
      end else if (t > PIX_MAX) begin
         return {1'b0, {(PIXEL_W-1){1'b1}}};
      end else if (t < PIX_MIN) begin
         return {1'b1, {(PIXEL_W-1){1'b0}}};
      end else begin
         return PIXEL_W'(t);
      end
   endfunction

   side_type last_side;
   assign last_side = side_ff[DIV_BITS-1];

   always_comb begin
      if (last_side.zero) begin
         out_result.pixel_u    = '0;
         out_result.pixel_v    = '0;
         out_result.in_image   = 1'b0;
         out_result.zero_depth = 1'b1;
      end else begin
         out_result.pixel_u    = pixel_of(quo_u, last_side.neg_u, last_side.ovf_u, CU_X);
         out_result.pixel_v    = pixel_of(quo_v, last_side.neg_v, last_side.ovf_v, CV_X);
         out_result.in_image   = last_side.in_bounds;
         out_result.zero_depth = 1'b0;
      end
   end

`ifndef SYNTH
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> !mid_empty) else $error("pop from empty queue");

   a_push_ok: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full) else $error("push into full result queue");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff)) else $error("pipeline moved while stalled");

   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      out_push && out_result.zero_depth |-> !out_result.in_image &&
      out_result.pixel_u == '0 && out_result.pixel_v == '0)
      else $error("zero depth result not cleared");
`endif

endmodule

// File: rtl/pinhole_point_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_point_projection
// projects world points onto the pixel grid of a configured pinhole camera
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req_      in         push / full            world_x, world_y, world_z
//   rsp_      out        pop / empty            pixel_u, pixel_v, in_image, zero_depth
//   csr_      in/out     psel, penable, pready  paddr, pwdata, prdata
//
// one point per cycle sustained while the result queue is not full; once its
// point is taken, a result reaches the rsp_ ports through the front queue,
// seven rotation and numerator stages, the 17 stage divider and the result queue
// reset is synchronous; no clearing pass
// a held result stalls the back pipeline as a whole; the front queue keeps
// taking points until it fills
// ----------------------------------------------------------------------------
module pinhole_point_projection #(
   parameter int IMG_WIDTH  = ppp_pkg::DEF_IMG_WIDTH,
   parameter int IMG_HEIGHT = ppp_pkg::DEF_IMG_HEIGHT,
   parameter int CENTER_U   = ppp_pkg::DEF_CENTER_U,
   parameter int CENTER_V   = ppp_pkg::DEF_CENTER_V
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input point queue
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [ppp_pkg::COORD_W-1:0]    req_world_x,
   input  logic signed [ppp_pkg::COORD_W-1:0]    req_world_y,
   input  logic signed [ppp_pkg::COORD_W-1:0]    req_world_z,
   // result queue
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [ppp_pkg::PIXEL_W-1:0]    rsp_pixel_u,
   output logic signed [ppp_pkg::PIXEL_W-1:0]    rsp_pixel_v,
   output logic                                  rsp_in_image,
   output logic                                  rsp_zero_depth,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ppp_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [ppp_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [ppp_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);
   import ppp_pkg::*;

   // configuration registers
   quat_type                  quat_ff;
   logic signed [COORD_W-1:0] trans_x_ff, trans_y_ff, trans_z_ff;
   logic [FOCAL_W-1:0]        focal_ff;

   csr_reg_type               csr_sel;
   logic                      csr_wr;

   // links between front, back and result queue
   logic                      mid_pop, mid_empty;
   diff_type                  mid_diff;
   logic                      out_push, out_full;
   result_type                out_result;
   logic [$bits(result_type)-1:0] rsp_head;
   result_type                rsp_item;

   assign csr_pready = 1'b1;
   assign csr_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   // write lands on the access cycle
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff.w  <= QUAT_W_RST;
         quat_ff.x  <= QUAT_X_RST;
         quat_ff.y  <= QUAT_Y_RST;
         quat_ff.z  <= QUAT_Z_RST;
         trans_x_ff <= TRANS_RST;
         trans_y_ff <= TRANS_RST;
         trans_z_ff <= TRANS_RST;
         focal_ff   <= FOCAL_RST;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_QUAT_W:  quat_ff.w  <= csr_pwdata[QUAT_W-1:0];
            REG_QUAT_X:  quat_ff.x  <= csr_pwdata[QUAT_W-1:0];
            REG_QUAT_Y:  quat_ff.y  <= csr_pwdata[QUAT_W-1:0];
            REG_QUAT_Z:  quat_ff.z  <= csr_pwdata[QUAT_W-1:0];
            REG_TRANS_X: trans_x_ff <= csr_pwdata[COORD_W-1:0];
            REG_TRANS_Y: trans_y_ff <= csr_pwdata[COORD_W-1:0];
            REG_TRANS_Z: trans_z_ff <= csr_pwdata[COORD_W-1:0];
            REG_FOCAL:   focal_ff   <= csr_pwdata[FOCAL_W-1:0];
         endcase
      end
   end

   // read back, zero extended
   always_comb begin
      unique case (csr_sel)
         REG_QUAT_W:  csr_prdata = CSR_DATA_W'(unsigned'(quat_ff.w));
         REG_QUAT_X:  csr_prdata = CSR_DATA_W'(unsigned'(quat_ff.x));
         REG_QUAT_Y:  csr_prdata = CSR_DATA_W'(unsigned'(quat_ff.y));
         REG_QUAT_Z:  csr_prdata = CSR_DATA_W'(unsigned'(quat_ff.z));
         REG_TRANS_X: csr_prdata = CSR_DATA_W'(unsigned'(trans_x_ff));
         REG_TRANS_Y: csr_prdata = CSR_DATA_W'(unsigned'(trans_y_ff));
         REG_TRANS_Z: csr_prdata = CSR_DATA_W'(unsigned'(trans_z_ff));
         REG_FOCAL:   csr_prdata = CSR_DATA_W'(focal_ff);
      endcase
   end

   // front: translation removal and the queue toward the back
   ppp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_world_x (req_world_x),
      .req_world_y (req_world_y),
      .req_world_z (req_world_z),
      .trans_x     (trans_x_ff),
      .trans_y     (trans_y_ff),
      .trans_z     (trans_z_ff),
      .mid_pop     (mid_pop),
      .mid_empty   (mid_empty),
      .mid_diff    (mid_diff)
   );

   // back: rotation, divide and rounding pipeline
   ppp_back #(
      .IMG_WIDTH  (IMG_WIDTH),
      .IMG_HEIGHT (IMG_HEIGHT),
      .CENTER_U   (CENTER_U),
      .CENTER_V   (CENTER_V)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .quat       (quat_ff),
      .focal_len  (focal_ff),
      .mid_empty  (mid_empty),
      .mid_diff   (mid_diff),
      .mid_pop    (mid_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_result (out_result)
   );

   // result queue parts the pipeline from the consumer
   ppp_fifo #(
      .WIDTH     ($bits(result_type)),
      .DEPTH_LOG (OUT_DEPTH_LOG)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_result),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_head),
      .empty (rsp_empty)
   );

   assign rsp_item       = result_type'(rsp_head);
   assign rsp_pixel_u    = rsp_item.pixel_u;
   assign rsp_pixel_v    = rsp_item.pixel_v;
   assign rsp_in_image   = rsp_item.in_image;
   assign rsp_zero_depth = rsp_item.zero_depth;

endmodule
